>>> hdl/circular_palette_color_blend_macros.svh
`ifndef CIRCULAR_PALETTE_COLOR_BLEND_MACROS_SVH
`define CIRCULAR_PALETTE_COLOR_BLEND_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cpcb_pkg.sv
`timescale 1ns / 1ps

package cpcb_pkg;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;
  localparam int QueueCntW = 2;
  localparam logic [23:0] RoundBias = 24'h000101;

  typedef struct packed {
    logic [2:0] window_first;
    logic [2:0] window_last;
    logic [7:0] position;
    logic [7:0] fraction;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       window_error;
  } color_t;

  typedef struct packed {
    logic [2:0] idx1;
    logic [2:0] idx2;
    logic [7:0] fraction;
    logic       window_error;
  } job_t;

  // Remainder of pos by a small constant through a reciprocal multiply.
  function automatic logic [2:0] rem_const(input logic [7:0] pos, input logic [2:0] d,
                                           input logic [14:0] recip);
    logic [22:0] prod;
    logic [7:0]  quot;
    logic [7:0]  back;
    logic [7:0]  rem;
    prod = {15'd0, pos} * {8'd0, recip};
    quot = {1'b0, prod[22:16]};
    back = 8'(quot * {5'd0, d});
    rem  = pos - back;
    return rem[2:0];
  endfunction

  function automatic logic [2:0] window_offset(input logic [7:0] pos, input logic [3:0] len);
    logic [2:0] r;
    case (len)
      4'd1:    r = 3'd0;
      4'd2:    r = {2'd0, pos[0]};
      4'd3:    r = rem_const(pos, 3'd3, 15'd21846);
      4'd4:    r = {1'b0, pos[1:0]};
      4'd5:    r = rem_const(pos, 3'd5, 15'd13108);
      4'd6:    r = rem_const(pos, 3'd6, 15'd10923);
      4'd7:    r = rem_const(pos, 3'd7, 15'd9363);
      4'd8:    r = pos[2:0];
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/cpcb_queue.sv
`timescale 1ns / 1ps
`include "circular_palette_color_blend_macros.svh"

module cpcb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpcb_pkg::job_t push_data,
  output logic           full,
  output logic           pop_valid,
  output cpcb_pkg::job_t pop_data,
  input  logic           pop_ready
);

  cpcb_pkg::job_t                   slots [cpcb_pkg::QueueDepth];
  logic [cpcb_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [cpcb_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [cpcb_pkg::QueueCntW-1:0]   count;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (count == cpcb_pkg::QueueCntW'(cpcb_pkg::QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CPCB_ASSERT_NEXT(queue_fill_chk, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "queue count did not grow on push")

endmodule

>>> hdl/cpcb_front.sv
`timescale 1ns / 1ps
`include "circular_palette_color_blend_macros.svh"

module cpcb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  cpcb_pkg::pixel_t pixel,
  output logic             push,
  output cpcb_pkg::job_t   push_data,
  input  logic             full
);

  logic             hold_valid;
  cpcb_pkg::pixel_t hold;
  logic             load;
  logic [3:0]       len;
  logic [2:0]       offset;
  logic [2:0]       idx1;

  assign pixel_stall = hold_valid && full;
  assign load        = pixel_valid && !pixel_stall;
  assign push        = hold_valid && !full;

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_comb begin
    len    = {1'b0, hold.window_last} - {1'b0, hold.window_first} + 4'd1;
    offset = cpcb_pkg::window_offset(hold.position, len);
    idx1   = offset + hold.window_first;
    push_data.idx1         = idx1;
    push_data.idx2         = (idx1 == hold.window_last) ? hold.window_first : idx1 + 3'd1;
    push_data.fraction     = hold.fraction;
    push_data.window_error = (hold.window_last < hold.window_first);
  end

  `CPCB_ASSERT_NEXT(front_hold_chk, clk, rst, hold_valid && full, hold_valid && $stable(hold), "held item lost while queue full")

endmodule

>>> hdl/cpcb_back.sv
`timescale 1ns / 1ps
`include "circular_palette_color_blend_macros.svh"

module cpcb_back #(
  parameter int PALETTE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  input  logic             job_valid,
  input  cpcb_pkg::job_t   job,
  output logic             job_ready,
  output logic             color_valid,
  input  logic             color_stall,
  output cpcb_pkg::color_t color
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [23:0]                pal [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_valid;
  logic                       cfg_hit;
  logic                       hit1;
  logic                       hit2;

  logic        a_valid;
  logic        a_ready;
  logic        a_load;
  logic [23:0] a_rd1;
  logic [23:0] a_rd2;
  logic        a_use1;
  logic        a_use2;
  logic [7:0]  a_fraction;
  logic        a_error;

  logic        b_valid;
  logic        b_ready;
  logic        b_load;
  logic [23:0] b_p1 [3];
  logic [23:0] b_p2 [3];
  logic        b_error;

  logic        c_valid;
  logic        c_ready;
  logic        c_load;
  cpcb_pkg::color_t c_item;

  logic [23:0] col1;
  logic [23:0] col2;
  logic [15:0] pre_lo;
  logic [15:0] pre_hi;
  logic [23:0] prod1 [3];
  logic [23:0] prod2 [3];
  logic [7:0]  chan [3];
  logic [23:0] t1;
  logic [23:0] t2;

  assign cfg_hit = cfg_write_en && ({1'b0, cfg_index} < 4'(PALETTE_ENTRIES));
  assign hit1    = ({1'b0, job.idx1} < 4'(PALETTE_ENTRIES));
  assign hit2    = ({1'b0, job.idx2} < 4'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (cfg_hit) begin
      pal[cfg_index[AW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (cfg_hit) begin
      pal_valid[cfg_index[AW-1:0]] <= 1'b1;
    end
  end

  assign c_ready   = !c_valid || !color_stall;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign job_ready = a_ready;
  assign a_load    = job_valid && a_ready;
  assign b_load    = a_valid && b_ready;
  assign c_load    = b_valid && c_ready;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_rd1      <= pal[job.idx1[AW-1:0]];
      a_rd2      <= pal[job.idx2[AW-1:0]];
      a_use1     <= hit1 && pal_valid[job.idx1[AW-1:0]];
      a_use2     <= hit2 && pal_valid[job.idx2[AW-1:0]];
      a_fraction <= job.fraction;
      a_error    <= job.window_error;
    end
  end

  always_comb begin
    col1   = a_use1 ? a_rd1 : 24'd0;
    col2   = a_use2 ? a_rd2 : 24'd0;
    pre_lo = {~a_fraction, ~a_fraction};
    pre_hi = {a_fraction, a_fraction};
    for (int k = 0; k < 3; k++) begin
      prod1[k] = {16'd0, col1[23-8*k -: 8]} * {8'd0, pre_lo};
      prod2[k] = {16'd0, col2[23-8*k -: 8]} * {8'd0, pre_hi};
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_p1    <= prod1;
      b_p2    <= prod2;
      b_error <= a_error;
    end
  end

  always_comb begin
    t1 = '0;
    t2 = '0;
    for (int k = 0; k < 3; k++) begin
      t1      = b_p1[k] + cpcb_pkg::RoundBias;
      t2      = b_p2[k] + cpcb_pkg::RoundBias;
      chan[k] = b_error ? 8'd0 : t1[23:16] + t2[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_item.red          <= chan[0];
      c_item.green        <= chan[1];
      c_item.blue         <= chan[2];
      c_item.window_error <= b_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= job_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  assign color_valid = c_valid;
  assign color       = c_item;

  `CPCB_ASSERT_NOW(back_black_chk, clk, rst, c_valid && c_item.window_error, c_item.red == 8'd0 && c_item.green == 8'd0 && c_item.blue == 8'd0, "error result is not black")
  `CPCB_ASSERT_NEXT(back_stage_a_chk, clk, rst, a_valid && !b_ready, a_valid && $stable(a_fraction) && $stable(a_error), "stage A changed while blocked")

endmodule

>>> hdl/circular_palette_color_blend.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// pixel     in         pixel_valid/stall    cpcb_pkg::pixel_t
// color     out        color_valid/stall    cpcb_pkg::color_t
// config    in         cfg_write_en         cfg_index, cfg_data
//
// One item is accepted per cycle and one result leaves per cycle when nothing stalls.
// On its way out an item passes the front hold register, the queue slot, the palette read register,
// the product register and the output register.
// Reset is synchronous, clears all control state and marks every palette entry invalid, so it reads as black.
// Each side can stall on its own; a two-entry queue separates the front and back.

module circular_palette_color_blend #(
  parameter int PALETTE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  cpcb_pkg::pixel_t pixel,
  output logic             color_valid,
  input  logic             color_stall,
  output cpcb_pkg::color_t color,
  input  logic             cfg_write_en,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  logic           push;
  cpcb_pkg::job_t push_data;
  logic           full;
  logic           job_valid;
  cpcb_pkg::job_t job;
  logic           job_ready;

  cpcb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  cpcb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (job_valid),
    .pop_data  (job),
    .pop_ready (job_ready)
  );

  cpcb_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .color        (color)
  );

endmodule

>>> tb/circular_palette_color_blend_tb.sv
`timescale 1ns / 1ps

module circular_palette_color_blend_tb;

  localparam int PaletteSize = 8;
  localparam int RandomPerPhase = 225;
  localparam int PhaseCount = 6;
  localparam int TailCycles = 10;
  localparam int CycleLimit = 600000;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
  typedef enum int {
    PAL_DIRECTED, PAL_BLACK, PAL_WHITE, PAL_CORNERS, PAL_RANDOM
  } palette_style_t;

  class blend_checker_t;
    logic [23:0]       palette [PaletteSize];
    cpcb_pkg::color_t  pending_colors [$];
    int                mismatches;
    int                checked;
    int                inverted;

    function new();
      foreach (palette[i]) palette[i] = '0;
      mismatches = 0;
      checked = 0;
      inverted = 0;
    endfunction

    function void set_entry(int idx, logic [23:0] value);
      palette[idx] = value;
    endfunction

    function int unsigned scale_chan(logic [7:0] c, int unsigned s);
      return (int'(c) * ((s << 8) + s) + int'(cpcb_pkg::RoundBias)) >> 16;
    endfunction

    function cpcb_pkg::color_t blend_pixel(cpcb_pkg::pixel_t p);
      cpcb_pkg::color_t c;
      int unsigned      len;
      int unsigned      idx1;
      int unsigned      idx2;
      int unsigned      f;
      logic [23:0]      c1;
      logic [23:0]      c2;
      c = '0;
      if (p.window_last < p.window_first) begin
        c.window_error = 1'b1;
        return c;
      end
      len = int'(p.window_last) - int'(p.window_first) + 1;
      idx1 = int'(p.position) % len + int'(p.window_first);
      idx2 = (idx1 == int'(p.window_last)) ? int'(p.window_first) : idx1 + 1;
      c1 = palette[idx1];
      c2 = palette[idx2];
      f = int'(p.fraction);
      c.red   = 8'(scale_chan(c1[23:16], 255 - f) + scale_chan(c2[23:16], f));
      c.green = 8'(scale_chan(c1[15:8], 255 - f) + scale_chan(c2[15:8], f));
      c.blue  = 8'(scale_chan(c1[7:0], 255 - f) + scale_chan(c2[7:0], f));
      return c;
    endfunction

    function void note_pixel(cpcb_pkg::pixel_t p);
      cpcb_pkg::color_t want;
      want = blend_pixel(p);
      if (want.window_error) inverted++;
      pending_colors.push_back(want);
    endfunction

    function void flag(string field, int want, int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_color(cpcb_pkg::color_t got);
      cpcb_pkg::color_t want;
      if (pending_colors.size() == 0) begin
        mismatches++;
        $display("%0t: color %0h arrived with none expected", $time, got);
        return;
      end
      want = pending_colors.pop_front();
      checked++;
      if (got.red !== want.red) flag("red", want.red, got.red);
      if (got.green !== want.green) flag("green", want.green, got.green);
      if (got.blue !== want.blue) flag("blue", want.blue, got.blue);
      if (got.window_error !== want.window_error) begin
        flag("window_error", want.window_error, got.window_error);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  cpcb_pkg::pixel_t pixel = '0;
  logic             color_valid;
  logic             color_stall = 1'b0;
  cpcb_pkg::color_t color;
  logic             cfg_write_en = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [23:0]      cfg_data = '0;

  blend_checker_t board;
  idle_mode_t     gap_mode = IDLE_NONE;
  idle_mode_t     stall_mode = IDLE_NONE;
  int             stall_left = 0;
  int             cycles = 0;
  int             items_sent = 0;
  int             settings_loaded = 0;

  circular_palette_color_blend u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .color        (color),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(idle_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE: begin
        return 0;
      end
      IDLE_LIGHT: begin
        if (r < 75) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(4, 12);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  function automatic cpcb_pkg::pixel_t make_pixel(int first, int last, int pos, int frac);
    cpcb_pkg::pixel_t p;
    p.window_first = 3'(first);
    p.window_last = 3'(last);
    p.position = 8'(pos);
    p.fraction = 8'(frac);
    return p;
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic cpcb_pkg::pixel_t rand_pixel();
    cpcb_pkg::pixel_t p;
    p.window_first = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 85) begin
      p.window_last = 3'($urandom_range(int'(p.window_first), 7));
    end else begin
      p.window_last = 3'($urandom_range(0, 7));
    end
    p.position = rand_byte();
    p.fraction = rand_byte();
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst && color_valid && !color_stall) board.check_color(color);
    if (stall_left > 0) begin
      color_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      color_stall <= 1'b0;
      stall_left = pick_gap(stall_mode);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding", cycles,
               board.pending_colors.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drive_pixel(input cpcb_pkg::pixel_t p);
    int gap;
    gap = pick_gap(gap_mode);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_stall);
    board.note_pixel(p);
    items_sent++;
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (board.pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic set_palette(input palette_style_t style);
    logic [23:0] value;
    for (int i = 0; i < PaletteSize; i++) begin
      case (style)
        PAL_DIRECTED: begin
          case (i)
            0: value = 24'hFF0000;
            1: value = 24'h00FF00;
            2: value = 24'h0000FF;
            3: value = 24'hFFFFFF;
            4: value = 24'h000000;
            5: value = 24'h123456;
            6: value = 24'h80807F;
            default: value = 24'hFEDCBA;
          endcase
        end
        PAL_BLACK: value = 24'h000000;
        PAL_WHITE: value = 24'hFFFFFF;
        PAL_CORNERS: begin
          value = {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                   $urandom_range(0, 1) ? 8'hFF : 8'h00};
        end
        default: value = 24'($urandom);
      endcase
      cfg_write_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= value;
      @(posedge clk);
      board.set_entry(i, value);
    end
    cfg_write_en <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    palette_style_t style;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The palette still holds its reset value here.
    gap_mode = IDLE_LIGHT;
    stall_mode = IDLE_LIGHT;
    drive_pixel(make_pixel(0, 7, 255, 128));
    drive_pixel(make_pixel(3, 3, 17, 255));
    drive_pixel(make_pixel(5, 2, 9, 40));
    drain();

    set_palette(PAL_DIRECTED);
    drive_pixel(make_pixel(0, 7, 0, 0));
    drive_pixel(make_pixel(0, 7, 0, 255));
    drive_pixel(make_pixel(0, 7, 7, 128));
    drive_pixel(make_pixel(0, 7, 255, 1));
    drive_pixel(make_pixel(2, 2, 200, 77));
    drive_pixel(make_pixel(7, 7, 0, 255));
    drive_pixel(make_pixel(3, 5, 4, 64));
    drive_pixel(make_pixel(3, 5, 2, 255));
    drive_pixel(make_pixel(1, 6, 255, 254));
    drive_pixel(make_pixel(0, 6, 13, 128));
    drive_pixel(make_pixel(2, 6, 255, 127));
    drive_pixel(make_pixel(0, 1, 1, 200));
    drive_pixel(make_pixel(4, 7, 3, 0));
    drive_pixel(make_pixel(3, 4, 1, 128));
    drive_pixel(make_pixel(7, 0, 0, 0));
    drive_pixel(make_pixel(1, 0, 255, 255));
    drive_pixel(make_pixel(7, 6, 128, 128));
    drive_pixel(make_pixel(0, 0, 255, 0));
    drive_pixel(make_pixel(5, 7, 100, 170));
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          style = PAL_WHITE;
          gap_mode = IDLE_NONE;
          stall_mode = IDLE_NONE;
        end
        1: begin
          style = PAL_RANDOM;
          gap_mode = IDLE_LIGHT;
          stall_mode = IDLE_NONE;
        end
        2: begin
          style = PAL_CORNERS;
          gap_mode = IDLE_NONE;
          stall_mode = IDLE_HEAVY;
        end
        3: begin
          style = PAL_RANDOM;
          gap_mode = IDLE_HEAVY;
          stall_mode = IDLE_HEAVY;
        end
        4: begin
          style = PAL_BLACK;
          gap_mode = IDLE_LIGHT;
          stall_mode = IDLE_LIGHT;
        end
        default: begin
          style = PAL_RANDOM;
          gap_mode = IDLE_HEAVY;
          stall_mode = IDLE_LIGHT;
        end
      endcase
      set_palette(style);
      for (int n = 0; n < RandomPerPhase; n++) drive_pixel(rand_pixel());
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d items over %0d palette settings", items_sent, settings_loaded);
    $display("%0d results checked, %0d inverted windows", board.checked, board.inverted);
    $display("Mismatches: %0d, results still outstanding: %0d", board.mismatches,
             board.pending_colors.size());
    if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cpcb_pkg.sv
hdl/cpcb_queue.sv
hdl/cpcb_front.sv
hdl/cpcb_back.sv
hdl/circular_palette_color_blend.sv
tb/circular_palette_color_blend_tb.sv
